@@ rtl/tcfd_pkg.sv @@
package tcfd_pkg;

    localparam int unsigned CFG_W       = 16;
    localparam int unsigned STAMP_W     = 32;
    localparam int unsigned STORE_SLOTS = 61;
    localparam int unsigned FRAME_W     = 60;
    localparam int unsigned POS_W       = 7;

    localparam logic [POS_W-1:0] POS_UNSYNCED   = 7'h7F;
    localparam logic [POS_W-1:0] POS_START      = 7'd0;
    localparam logic [POS_W-1:0] POS_LAST_SLOT  = 7'd60;
    localparam logic [POS_W-1:0] FRAME_LEN      = 7'd59;
    localparam logic [POS_W-1:0] FRAME_LEN_LEAP = 7'd60;

    localparam int unsigned BIT_START  = 0;
    localparam int unsigned BIT_LEAP   = 19;
    localparam int unsigned BIT_TIME   = 20;
    localparam int unsigned BIT_END    = 59;

    localparam logic [CFG_W-1:0] PULSE_MIN_RST      = 16'd500;
    localparam logic [CFG_W-1:0] PULSE_MAX_RST      = 16'd2500;
    localparam logic [CFG_W-1:0] ONE_THRESHOLD_RST  = 16'd1500;
    localparam logic [CFG_W-1:0] SECOND_MIN_RST     = 16'd9500;
    localparam logic [CFG_W-1:0] SECOND_MAX_RST     = 16'd10500;
    localparam logic [CFG_W-1:0] MINUTE_GAP_MIN_RST = 16'd19500;
    localparam logic [CFG_W-1:0] MINUTE_GAP_MAX_RST = 16'd20500;

    typedef enum logic [2:0] {
        CFG_PULSE_MIN      = 3'd0,
        CFG_PULSE_MAX      = 3'd1,
        CFG_ONE_THRESHOLD  = 3'd2,
        CFG_SECOND_MIN     = 3'd3,
        CFG_SECOND_MAX     = 3'd4,
        CFG_MINUTE_GAP_MIN = 3'd5,
        CFG_MINUTE_GAP_MAX = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0] pulse_min;
        logic [CFG_W-1:0] pulse_max;
        logic [CFG_W-1:0] one_threshold;
        logic [CFG_W-1:0] second_min;
        logic [CFG_W-1:0] second_max;
        logic [CFG_W-1:0] minute_gap_min;
        logic [CFG_W-1:0] minute_gap_max;
    } cfg_t;

    typedef struct packed {
        logic                      valid;
        logic [FRAME_W-1:0]        frame_bits;
        logic                      frame_valid;
        logic signed [STAMP_W-1:0] frame_stamp;
    } result_t;

endpackage

@@ rtl/time_code_frame_decoder_unit.sv @@
// minute time code frame decoder
// input channel s_*: one beat per received pulse (timestamp, pulse width, interval)
// result channel m_*: one beat per minute gap with the 60 frame bits, a check flag
//   and the timestamp of the pulse that closed the frame
// config channel cfg_*: index 0..6 selects a 16-bit window register, always ready;
//   write only while no beat is in flight; other indexes are ignored
// a result beat passes the input register and then the result register on its way to m_*
// throughput: one input beat per cycle while s_ready is high; the frame state update is a single
//   compare-and-shift step between the input register and the result register
// pulses outside the windows produce no beat; they clear the frame and desync
// reset: windows take their default values, the decoder starts unsynced and the
//   pipeline empties
// when m_ready is low the result register holds and the input register keeps
//   accepting until it too holds a beat; s_ready then drops
module time_code_frame_decoder_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_stamp,
    input  logic [15:0]         s_pulse_width,
    input  logic [15:0]         s_interval,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [59:0]         m_frame_bits,
    output logic                m_frame_valid,
    output logic signed [31:0]  m_frame_stamp
);
    import tcfd_pkg::*;

    cfg_t    cfg;
    result_t result;

    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic signed [STAMP_W-1:0] in_stamp_reg;
    logic [CFG_W-1:0]          in_width_reg;
    logic [CFG_W-1:0]          in_interval_reg;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [FRAME_W-1:0]        out_bits_reg;
    logic                      out_ok_reg;
    logic signed [STAMP_W-1:0] out_stamp_reg;

    logic                      advance;
    logic                      step;
    logic                      s_fire;

    assign cfg_ready = 1'b1;

    tcfd_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    tcfd_frame_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .step        (step),
        .stamp       (in_stamp_reg),
        .pulse_width (in_width_reg),
        .interval    (in_interval_reg),
        .result      (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (result.valid) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_stamp_reg    <= s_stamp;
            in_width_reg    <= s_pulse_width;
            in_interval_reg <= s_interval;
        end
        if (result.valid) begin
            out_bits_reg  <= result.frame_bits;
            out_ok_reg    <= result.frame_valid;
            out_stamp_reg <= result.frame_stamp;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_frame_bits  = out_bits_reg;
    assign m_frame_valid = out_ok_reg;
    assign m_frame_stamp = out_stamp_reg;

`ifndef SYNTHESIS
    a_good_frame_markers: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_valid |-> m_frame_bits[20] && !m_frame_bits[0] && !m_frame_bits[59])
        else $error("checked frame with bad marker bits");

    a_bad_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_valid |-> m_frame_bits == '0)
        else $error("failed frame carries nonzero bits");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled with room in the pipeline");

    a_result_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid ##1 m_valid |-> $past(in_valid_reg))
        else $error("result beat without a pending pulse");
`endif

endmodule

@@ rtl/tcfd_cfg_regs.sv @@
module tcfd_cfg_regs (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   wr_en,
    input  logic [2:0]             wr_index,
    input  logic [15:0]            wr_data,
    output tcfd_pkg::cfg_t         cfg
);
    import tcfd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                CFG_PULSE_MIN:      cfg_next.pulse_min      = wr_data;
                CFG_PULSE_MAX:      cfg_next.pulse_max      = wr_data;
                CFG_ONE_THRESHOLD:  cfg_next.one_threshold  = wr_data;
                CFG_SECOND_MIN:     cfg_next.second_min     = wr_data;
                CFG_SECOND_MAX:     cfg_next.second_max     = wr_data;
                CFG_MINUTE_GAP_MIN: cfg_next.minute_gap_min = wr_data;
                CFG_MINUTE_GAP_MAX: cfg_next.minute_gap_max = wr_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_min      <= PULSE_MIN_RST;
            cfg_reg.pulse_max      <= PULSE_MAX_RST;
            cfg_reg.one_threshold  <= ONE_THRESHOLD_RST;
            cfg_reg.second_min     <= SECOND_MIN_RST;
            cfg_reg.second_max     <= SECOND_MAX_RST;
            cfg_reg.minute_gap_min <= MINUTE_GAP_MIN_RST;
            cfg_reg.minute_gap_max <= MINUTE_GAP_MAX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/tcfd_frame_core.sv @@
module tcfd_frame_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tcfd_pkg::cfg_t                       cfg,
    input  logic                                 step,
    input  logic signed [tcfd_pkg::STAMP_W-1:0]  stamp,
    input  logic [tcfd_pkg::CFG_W-1:0]           pulse_width,
    input  logic [tcfd_pkg::CFG_W-1:0]           interval,
    output tcfd_pkg::result_t                    result
);
    import tcfd_pkg::*;

    logic [STORE_SLOTS-1:0] store_reg;
    logic [STORE_SLOTS-1:0] store_next;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;

    logic                   pulse_ok;
    logic                   sec_ok;
    logic                   gap_ok;
    logic                   in_range;
    logic                   is_one;
    logic [STORE_SLOTS-1:0] store_a;
    logic [POS_W-1:0]       pos_a;
    logic                   len_ok;
    logic                   frame_ok;

    assign pulse_ok = (cfg.pulse_min <= pulse_width) && (pulse_width <= cfg.pulse_max);
    assign sec_ok   = (cfg.second_min <= interval) && (interval <= cfg.second_max);
    assign gap_ok   = (cfg.minute_gap_min <= interval) && (interval <= cfg.minute_gap_max);
    assign in_range = pos_reg <= POS_LAST_SLOT;
    assign is_one   = pulse_width > cfg.one_threshold;

    always_comb begin
        if (in_range) begin
            store_a = store_reg | ({{(STORE_SLOTS-1){1'b0}}, is_one} << pos_reg);
            pos_a   = pos_reg + 7'd1;
        end else begin
            store_a = '0;
            pos_a   = POS_UNSYNCED;
        end
    end

    assign len_ok = (pos_a == FRAME_LEN) || (store_a[BIT_LEAP] && (pos_a == FRAME_LEN_LEAP));

    assign frame_ok = len_ok && !store_a[BIT_START] && store_a[BIT_TIME] && !store_a[BIT_END]
                      && !(^store_a[28:21]) && !(^store_a[35:29]) && !(^store_a[58:36]);

    always_comb begin
        store_next = store_reg;
        pos_next   = pos_reg;
        if (step) begin
            if (!(pulse_ok && (sec_ok || gap_ok))) begin
                store_next = '0;
                pos_next   = POS_UNSYNCED;
            end else if (gap_ok) begin
                store_next = '0;
                pos_next   = POS_START;
            end else begin
                store_next = store_a;
                pos_next   = pos_a;
            end
        end
    end

    always_comb begin
        result.valid       = step && pulse_ok && gap_ok;
        result.frame_valid = frame_ok;
        result.frame_bits  = frame_ok ? store_a[FRAME_W-1:0] : '0;
        result.frame_stamp = stamp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            store_reg <= '0;
            pos_reg   <= POS_UNSYNCED;
        end else begin
            store_reg <= store_next;
            pos_reg   <= pos_next;
        end
    end

endmodule
